/* hw/rtl/cdf_pkg.sv */
// ----------------------------------------------------------------------------
// cdf_pkg
// shared widths, register indexes and payload types of the contact drag core
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam int VW    = 32;  // velocity component, Q15.16
  localparam int MW    = 32;  // body mass, Q16.16
  localparam int NW    = 16;  // normal component, Q1.15
  localparam int RFW   = 17;  // reciprocal flotation, Q1.16
  localparam int SRW   = 10;  // step rate
  localparam int FW    = 48;  // force component, Q31.16
  localparam int SQW   = 64;  // sum of squared velocity
  localparam int DPW   = 48;  // one velocity times normal product
  localparam int DW    = 50;  // dot product v.n
  localparam int NDW   = 66;  // n_i times dot product
  localparam int NUMW  = 63;  // magnitude of n_i times dot product
  localparam int NNW   = 32;  // n.n
  localparam int QW    = 33;  // projection quotient magnitude
  localparam int PW    = 35;  // projected velocity, signed
  localparam int LIMW  = 42;  // mass times step rate
  localparam int SPDW  = 32;  // speed
  localparam int EFFW  = 30;  // drag factor from flotation
  localparam int GAINW = 42;  // clamped gain
  localparam int CFGW  = 17;  // widest register
  localparam int CIW   = 3;   // register index width

  localparam logic [CIW-1:0] REG_RECIP_FLOTATION   = 3'd0;
  localparam logic [CIW-1:0] REG_NORMAL_X          = 3'd1;
  localparam logic [CIW-1:0] REG_NORMAL_Y          = 3'd2;
  localparam logic [CIW-1:0] REG_NORMAL_Z          = 3'd3;
  localparam logic [CIW-1:0] REG_PASSABLE_MATERIAL = 3'd4;
  localparam logic [CIW-1:0] REG_STEP_RATE         = 3'd5;
  localparam logic [CIW-1:0] REG_CONTACT_VALID     = 3'd6;

  localparam logic [RFW-1:0] RF_ONE     = 17'd65536;
  localparam logic [13:0]    DRAG_SCALE = 14'd10000;

  typedef logic [2:0][VW-1:0] vel3_t;
  typedef logic [2:0][NW-1:0] nrm3_t;
  typedef logic [2:0][PW-1:0] proj3_t;
  typedef logic [2:0][FW-1:0] force3_t;

  typedef struct packed {
    vel3_t           v;
    logic [SQW-1:0]  sq;
    logic [DW-1:0]   d;
    logic [LIMW-1:0] limit;
  } front_t;

endpackage

/* hw/rtl/cdf_front.sv */
// ----------------------------------------------------------------------------
// cdf_front
// squares, dot product with the normal and the gain limit, two stages
// ----------------------------------------------------------------------------
module cdf_front import cdf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  vel3_t          vel,
  input  logic [MW-1:0]  mass,
  input  nrm3_t          nrm,
  input  logic [SRW-1:0] step_rate,
  output logic           out_valid,
  output front_t         out_data
);

  logic                   vld1;
  vel3_t                  v1;
  logic [2:0][SQW-1:0]    sq1;
  logic [2:0][DPW-1:0]    dp1;
  logic [LIMW-1:0]        lim1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= {{(SQW-VW){vel[i][VW-1]}}, vel[i]} * {{(SQW-VW){vel[i][VW-1]}}, vel[i]};
        dp1[i] <= {{(DPW-VW){vel[i][VW-1]}}, vel[i]} * {{(DPW-NW){nrm[i][NW-1]}}, nrm[i]};
      end
      v1   <= vel;
      lim1 <= {{(LIMW-MW){1'b0}}, mass} * {{(LIMW-SRW){1'b0}}, step_rate};
      out_data.v     <= v1;
      out_data.sq    <= sq1[0] + sq1[1] + sq1[2];
      out_data.d     <= {{(DW-DPW){dp1[0][DPW-1]}}, dp1[0]}
                      + {{(DW-DPW){dp1[1][DPW-1]}}, dp1[1]}
                      + {{(DW-DPW){dp1[2][DPW-1]}}, dp1[2]};
      out_data.limit <= lim1;
    end
  end

endmodule

/* hw/rtl/cdf_isqrt.sv */
// ----------------------------------------------------------------------------
// cdf_isqrt
// pipelined integer square root, one result bit per stage, with sideband
// ----------------------------------------------------------------------------
module cdf_isqrt import cdf_pkg::*; #(
  parameter int SW = 42
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SQW-1:0]  x,
  input  logic [SW-1:0]   side_in,
  output logic [SPDW-1:0] root,
  output logic [SW-1:0]   side_out
);

  localparam int NST = SQW / 2;

  logic [SQW-1:0] xs [0:NST];
  logic [SQW-1:0] rs [0:NST];
  logic [SW-1:0]  ss [0:NST];

  assign xs[0] = x;
  assign rs[0] = '0;
  assign ss[0] = side_in;

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam logic [SQW-1:0] B = {{(SQW-1){1'b0}}, 1'b1} << (SQW - 2 - 2 * k);
    logic [SQW-1:0] trial;
    assign trial = rs[k] + B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xs[k] >= trial) begin
          xs[k+1] <= xs[k] - trial;
          rs[k+1] <= (rs[k] >> 1) + B;
        end else begin
          xs[k+1] <= xs[k];
          rs[k+1] <= rs[k] >> 1;
        end
        ss[k+1] <= ss[k];
      end
    end
  end

  assign root     = rs[NST][SPDW-1:0];
  assign side_out = ss[NST];

endmodule

/* hw/rtl/cdf_gain.sv */
// ----------------------------------------------------------------------------
// cdf_gain
// drag gain from speed, clamped to mass times step rate, then aligned
// ----------------------------------------------------------------------------
module cdf_gain import cdf_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SPDW-1:0]  speed,
  input  logic [EFFW-1:0]  eff,
  input  logic [LIMW-1:0]  limit,
  output logic [GAINW-1:0] gain
);

  logic [SPDW+EFFW-1:0] prod1;
  logic [LIMW-1:0]      lim1;
  logic [GAINW-1:0]     g2;
  logic [GAINW-1:0]     g3;
  logic [SPDW+EFFW-17:0] raw;

  assign raw = prod1[SPDW+EFFW-1:16];

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= {{EFFW{1'b0}}, speed} * {{SPDW{1'b0}}, eff};
      lim1  <= limit;
      g2    <= (raw > {{(SPDW+EFFW-16-LIMW){1'b0}}, lim1}) ? lim1 : raw[GAINW-1:0];
      g3    <= g2;
      gain  <= g3;
    end
  end

endmodule

/* hw/rtl/cdf_project.sv */
// ----------------------------------------------------------------------------
// cdf_project
// removes the normal component of the velocity with a pipelined divider unless skip is set
// ----------------------------------------------------------------------------
module cdf_project import cdf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  vel3_t          vel,
  input  logic [DW-1:0]  d,
  input  nrm3_t          nrm,
  input  logic [NNW-1:0] nn,
  input  logic           skip,
  output logic           out_valid,
  output proj3_t         p
);

  logic                 vld1;
  vel3_t                v1;
  logic [2:0][NDW-1:0]  nd1;
  logic [2:0][NDW-1:0]  mag1;

  logic [2:0][NUMW-1:0] rem [0:QW];
  logic [2:0][QW-1:0]   quo [0:QW];
  logic [2:0]           ngs [0:QW];
  vel3_t                vs  [0:QW];
  logic                 vv  [0:QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = nd1[i][NDW-1] ? (~nd1[i] + {{(NDW-1){1'b0}}, 1'b1}) : nd1[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      vv[0] <= 1'b0;
    end else if (en) begin
      vld1  <= in_valid;
      vv[0] <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nd1[i]    <= {{(NDW-DW){d[DW-1]}}, d} * {{(NDW-NW){nrm[i][NW-1]}}, nrm[i]};
        rem[0][i] <= mag1[i][NUMW-1:0];
        quo[0][i] <= '0;
        ngs[0][i] <= nd1[i][NDW-1];
      end
      v1    <= vel;
      vs[0] <= v1;
    end
  end

  // restoring division, quotient bit QW-k decided in stage k
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int SH = QW - k;
    logic [NUMW+1:0] dsh;
    logic [2:0]      ge;
    assign dsh = {{(NUMW+2-NNW){1'b0}}, nn} << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = {2'b00, rem[k-1][i]} >= dsh;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k] <= 1'b0;
      end else if (en) begin
        vv[k] <= vv[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem[k][i] <= ge[i] ? (rem[k-1][i] - dsh[NUMW-1:0]) : rem[k-1][i];
          quo[k][i] <= quo[k-1][i] | ({{(QW-1){1'b0}}, ge[i]} << SH);
        end
        ngs[k] <= ngs[k-1];
        vs[k]  <= vs[k-1];
      end
    end
  end

  logic [2:0][PW-1:0] vx;
  logic [2:0][PW-1:0] qs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = {{(PW-VW){vs[QW][i][VW-1]}}, vs[QW][i]};
      qs[i] = ngs[QW][i] ? (~{{(PW-QW){1'b0}}, quo[QW][i]} + {{(PW-1){1'b0}}, 1'b1})
                         : {{(PW-QW){1'b0}}, quo[QW][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p[i] <= skip ? vx[i] : (vx[i] - qs[i]);
      end
    end
  end

endmodule

/* hw/rtl/cdf_scale.sv */
// ----------------------------------------------------------------------------
// cdf_scale
// force = -gain * p / 2^16 with saturation, zero unless apply is set, three stages
// ----------------------------------------------------------------------------
module cdf_scale import cdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  proj3_t           p,
  input  logic [GAINW-1:0] gain,
  input  logic             contact_valid,
  output logic             out_valid,
  output force3_t          force_out,
  output logic             apply
);

  localparam int HIW = GAINW - 16 + PW;
  localparam int LOW = 16 + PW;
  localparam int SUMW = HIW + 1;

  logic                 vld1, vld2;
  logic [2:0][PW-1:0]   m1;
  logic [2:0]           pos1, pos2;
  logic [GAINW-1:0]     gain1;
  logic                 app1, app2;
  logic [2:0][HIW-1:0]  hi2;
  logic [2:0][LOW-1:0]  lo2;
  logic [2:0][SUMW-1:0] q;
  logic [2:0][FW-1:0]   f;

  localparam logic [SUMW-1:0] MAXPOS = {{(SUMW-FW+1){1'b0}}, {(FW-1){1'b1}}};
  localparam logic [SUMW-1:0] MAXNEG = {{(SUMW-FW){1'b0}}, 1'b1, {(FW-1){1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = {1'b0, hi2[i]} + {{(SUMW-LOW+16){1'b0}}, lo2[i][LOW-1:16]};
      if (pos2[i]) begin
        f[i] = (q[i] > MAXNEG) ? ~MAXNEG[FW-1:0] + {{(FW-1){1'b0}}, 1'b1}
                               : ~q[i][FW-1:0] + {{(FW-1){1'b0}}, 1'b1};
      end else begin
        f[i] = (q[i] > MAXPOS) ? MAXPOS[FW-1:0] : q[i][FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      vld2      <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1[i]   <= p[i][PW-1] ? (~p[i] + {{(PW-1){1'b0}}, 1'b1}) : p[i];
        pos1[i] <= !p[i][PW-1] && (p[i] != '0);
        hi2[i]  <= {{PW{1'b0}}, gain1[GAINW-1:16]} * {{(GAINW-16){1'b0}}, m1[i]};
        lo2[i]  <= {{PW{1'b0}}, gain1[15:0]} * {16'b0, m1[i]};
        force_out[i] <= app2 ? f[i] : '0;
      end
      gain1 <= gain;
      app1  <= contact_valid && (gain != '0);
      pos2  <= pos1;
      app2  <= app1;
      apply <= app2;
    end
  end

endmodule

/* hw/rtl/contact_drag_force_core.sv */
// ----------------------------------------------------------------------------
// contact_drag_force_core
// drag force on a body touching a contact: gain from speed and flotation,
// clamped to mass times step rate, normal component removed when required
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents
//  s_axis    in   128    velocity_x, velocity_y, velocity_z, body_mass
//  m_axis    out  152    force_x, force_y, force_z, force_apply, zero fill
//  cfg       in   17     register write, index per register list
//
//  one item per cycle while the skid entry is empty; the 33-stage projection
//  divider sits behind the front and ahead of the scaler
//  rst is synchronous and clears valid bits and configuration registers to their defaults
//  a two-entry output (register plus skid) keeps taking items while one waits;
//  the pipeline freezes only while the skid entry is occupied
//  derived factors (flotation squared, n.n) are registered after a write: rf_sq then eff, nsq then nn
//
module contact_drag_force_core import cdf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // velocity_x [31:0], velocity_y [63:32], velocity_z [95:64], body_mass [127:96]
  input  logic [127:0]    s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // force_x [47:0], force_y [95:48], force_z [143:96], force_apply [144], zero [151:145]
  output logic [151:0]    m_axis_tdata,
  input  logic            cfg_we,
  input  logic [CIW-1:0]  cfg_index,
  input  logic [CFGW-1:0] cfg_data
);

  localparam int OW = 3 * FW + 1;

  // configuration registers
  logic [RFW-1:0] recip_flotation;
  nrm3_t          nrm;
  logic           passable_material;
  logic [SRW-1:0] step_rate;
  logic           contact_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      recip_flotation   <= RF_ONE;
      nrm[0]            <= '0;
      nrm[1]            <= 16'sd32767;
      nrm[2]            <= '0;
      passable_material <= 1'b0;
      step_rate         <= 10'd50;
      contact_valid     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECIP_FLOTATION:   recip_flotation   <= cfg_data;
        REG_NORMAL_X:          nrm[0]            <= cfg_data[NW-1:0];
        REG_NORMAL_Y:          nrm[1]            <= cfg_data[NW-1:0];
        REG_NORMAL_Z:          nrm[2]            <= cfg_data[NW-1:0];
        REG_PASSABLE_MATERIAL: passable_material <= cfg_data[0];
        REG_STEP_RATE:         step_rate         <= cfg_data[SRW-1:0];
        REG_CONTACT_VALID:     contact_valid     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // factors derived from the registers, recomputed every cycle
  logic [RFW-1:0]      rf;
  logic [2*RFW-1:0]    rf_sq;
  logic [2*RFW+13:0]   eff_prod;
  logic [EFFW-1:0]     eff;
  logic [2:0][NNW-1:0] nsq;
  logic [NNW-1:0]      nn;

  assign rf       = (recip_flotation > RF_ONE) ? RF_ONE : recip_flotation;
  assign eff_prod = {14'b0, rf_sq} * {{(2*RFW){1'b0}}, DRAG_SCALE};

  always_ff @(posedge clk) begin
    rf_sq <= {{RFW{1'b0}}, rf} * {{RFW{1'b0}}, rf};
    eff   <= eff_prod[EFFW+15:16];
    for (int i = 0; i < 3; i++) begin
      nsq[i] <= {{(NNW-NW){nrm[i][NW-1]}}, nrm[i]} * {{(NNW-NW){nrm[i][NW-1]}}, nrm[i]};
    end
    nn <= nsq[0] + nsq[1] + nsq[2];
  end

  // pipeline advance, held only while the skid entry is full
  logic en;
  logic skv;
  assign en            = !skv;
  assign s_axis_tready = en;

  vel3_t vin;
  assign vin[0] = s_axis_tdata[31:0];
  assign vin[1] = s_axis_tdata[63:32];
  assign vin[2] = s_axis_tdata[95:64];

  logic   fr_valid;
  front_t fr;

  cdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .vel       (vin),
    .mass      (s_axis_tdata[127:96]),
    .nrm       (nrm),
    .step_rate (step_rate),
    .out_valid (fr_valid),
    .out_data  (fr)
  );

  // speed path runs beside the projection path, same en, same depth
  logic [SPDW-1:0] speed;
  logic [LIMW-1:0] lim_d;
  logic [GAINW-1:0] gain;

  cdf_isqrt #(.SW(LIMW)) u_isqrt (
    .clk      (clk),
    .en       (en),
    .x        (fr.sq),
    .side_in  (fr.limit),
    .root     (speed),
    .side_out (lim_d)
  );

  cdf_gain u_gain (
    .clk   (clk),
    .en    (en),
    .speed (speed),
    .eff   (eff),
    .limit (lim_d),
    .gain  (gain)
  );

  logic   pj_valid;
  proj3_t pj;

  cdf_project u_project (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .vel       (fr.v),
    .d         (fr.d),
    .nrm       (nrm),
    .nn        (nn),
    .skip      (passable_material || (nn == '0)),
    .out_valid (pj_valid),
    .p         (pj)
  );

  logic    sc_valid;
  force3_t frc;
  logic    sc_apply;

  cdf_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (pj_valid),
    .p             (pj),
    .gain          (gain),
    .contact_valid (contact_valid),
    .out_valid     (sc_valid),
    .force_out     (frc),
    .apply         (sc_apply)
  );

  // output register and skid entry
  logic          ov;
  logic [OW-1:0] od;
  logic [OW-1:0] skd;
  logic [OW-1:0] ld;
  logic          take;

  assign ld   = {sc_apply, frc[2], frc[1], frc[0]};
  assign take = !ov || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      skv <= 1'b0;
    end else if (skv) begin
      if (take) begin
        ov  <= 1'b1;
        od  <= skd;
        skv <= 1'b0;
      end
    end else if (take) begin
      ov <= sc_valid;
      if (sc_valid) begin
        od <= ld;
      end
    end else if (sc_valid) begin
      skv <= 1'b1;
      skd <= ld;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {{(152-OW){1'b0}}, od};

endmodule
